@@ rtl/core/phl_pkg.sv @@
`default_nettype none

package phl_pkg;

    // CORDIC datapath widths: x/y carry the vectoring gain growth, z the angle sum
    localparam int XW      = 36;
    localparam int ZW      = 34;
    localparam int TAB_LEN = 40;

    // radians * 2^30 for atan(2^-i)
    localparam logic [29:0] ATAN_Q30 [TAB_LEN] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
        30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
        30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
        30'd32,        30'd16,        30'd8,         30'd4,         30'd2,
        30'd1,         30'd0,         30'd0,         30'd0,         30'd0,
        30'd0,         30'd0,         30'd0,         30'd0,         30'd0
    };

    localparam logic [29:0]        GAIN_Q30   = 30'd652032874;
    localparam logic signed [31:0] DEG_TO_Q30 = 32'sd2012227627;
    localparam logic signed [33:0] DEG90      = 34'sd900000000;
    localparam logic signed [33:0] DEG180     = 34'sd1800000000;
    localparam logic signed [33:0] DEG360     = 34'sd3600000000;
    localparam logic [47:0]        TOTAL_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic [22:0]        RADIUS_RST = 23'd6371000;
    localparam logic [9:0]         MM_PER_M   = 10'd1000;

    // CORDIC job tags
    localparam logic [1:0] TAG_SLAT = 2'd0;  // sin of half latitude delta
    localparam logic [1:0] TAG_SLON = 2'd1;  // sin of half longitude delta
    localparam logic [1:0] TAG_CLA  = 2'd2;  // cos of previous latitude
    localparam logic [1:0] TAG_CLB  = 2'd3;  // cos of current latitude

    typedef struct packed {
        logic                 valid;
        logic                 vec;
        logic [1:0]           tag;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cord_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CONV,
        ST_ROTW,
        ST_MUL,
        ST_SQS,
        ST_SQRT,
        ST_ATAN,
        ST_ATANW,
        ST_SCALE,
        ST_MM,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/polyline_haversine_length.sv @@
// Channel   Dir  Handshake                 Payload
// s_        in   s_tvalid / s_tready       s_tdata: latitude, longitude; s_tuser: first_point
// m_        out  m_tvalid / m_tready       m_tdata: segment_mm, total_mm; m_tuser: saturated
// cfg_      in   cfg_valid / cfg_ready     cfg_data: radius_m
//
// One point is in flight at a time. A point that has a predecessor makes two passes
// through the CORDIC cell row (rotation, then vectoring) and runs the 31-step
// bit-serial square roots. A point that starts a polyline or has no predecessor goes
// straight from IDLE to OUT. Reset (aresetn low, synchronous) clears the
// totals, the previous point and the radius to 6371000 m. The result register lets
// the next point enter while a result waits on m_tready; a finished point holds in
// its last state until the result register frees up.
`default_nettype none

module polyline_haversine_length #(
    parameter int CORDIC_STEPS = 28
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [30:0] latitude, [62:31] longitude, [63] zero
    input  wire logic        s_tuser,   // [0] first_point
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // [34:0] segment_mm, [82:35] total_mm, [87:83] zero
    output logic             m_tuser,   // [0] saturated
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [22:0] cfg_data   // [22:0] radius_m
);

    // iterations beyond the table length add nothing
    localparam int NCELL = (CORDIC_STEPS > phl_pkg::TAB_LEN) ? phl_pkg::TAB_LEN : CORDIC_STEPS;

    phl_pkg::state_t state_reg;
    phl_pkg::state_t state_next;
    logic [2:0]      cnt_reg;

    logic [22:0]        radius_reg;
    logic signed [30:0] prev_lat_reg;
    logic signed [31:0] prev_lon_reg;
    logic               have_prev_reg;
    logic [47:0]        total_reg;
    logic               sat_reg;

    logic signed [30:0] cur_lat_reg;
    logic signed [31:0] cur_lon_reg;
    logic               first_reg;
    logic               calc_reg;

    logic signed [31:0] dlat_reg;
    logic signed [31:0] dlon_reg;
    logic signed [31:0] la_reg;
    logic signed [31:0] lb_reg;
    logic               neg_a_reg;
    logic               neg_b_reg;

    logic signed [31:0] conv_d;
    logic signed [63:0] prod_reg;
    logic               conv_v_reg;
    logic [1:0]         conv_tag_reg;
    logic signed [63:0] zsum;
    logic signed [63:0] zq;

    phl_pkg::cord_t                chain_w [NCELL+1];
    phl_pkg::cord_t                feed;
    phl_pkg::cord_t                chain_out;
    logic signed [phl_pkg::XW-1:0] neg_x;

    logic signed [31:0] sl_reg;
    logic signed [31:0] sn_reg;
    logic signed [31:0] ca_reg;
    logic signed [31:0] cb_reg;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_reg;
    logic signed [63:0] mul_sh;
    logic signed [31:0] mul_q30;
    logic signed [31:0] cc_reg;
    logic signed [31:0] hsl_reg;
    logic signed [31:0] t_reg;
    logic signed [32:0] hs;
    logic [30:0]        h_clamp;
    logic [30:0]        h_reg;

    logic        ys_done;
    logic        xc_done;
    logic [30:0] ys_root;
    logic [30:0] xc_root;

    logic [31:0] ang_reg;
    logic [54:0] q_reg;
    logic [35:0] mm;
    logic [34:0] seg_reg;

    logic [48:0] sum;
    logic [47:0] total_new;
    logic        sat_new;

    logic [34:0] m_seg_reg;
    logic [47:0] m_total_reg;
    logic        m_sat_reg;
    logic        m_tvalid_reg;

    logic accept;
    logic out_free;
    logic conv_issue;
    logic atan_issue;
    logic sqrt_start;
    logic commit;

    function automatic logic signed [31:0] wrap_deg(input logic signed [33:0] d);
        logic signed [33:0] r;
        r = d;
        if (d >= phl_pkg::DEG180) begin
            r = d - phl_pkg::DEG360;
        end else if (d < -phl_pkg::DEG180) begin
            r = d + phl_pkg::DEG360;
        end
        return r[31:0];
    endfunction

    // fold a latitude beyond the pole back; cosine then changes sign
    function automatic logic [32:0] fold_lat(input logic signed [30:0] l);
        logic signed [33:0] w;
        logic signed [33:0] r;
        logic               n;
        w = 34'(l);
        r = w;
        n = 1'b0;
        if (w > phl_pkg::DEG90) begin
            r = w - phl_pkg::DEG180;
            n = 1'b1;
        end else if (w < -phl_pkg::DEG90) begin
            r = w + phl_pkg::DEG180;
            n = 1'b1;
        end
        return {n, r[31:0]};
    endfunction

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign chain_out = chain_w[NCELL];

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            phl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (!s_tuser && have_prev_reg) ? phl_pkg::ST_PREP
                                                              : phl_pkg::ST_OUT;
                end
            end
            phl_pkg::ST_PREP:  state_next = phl_pkg::ST_CONV;
            phl_pkg::ST_CONV: begin
                if (cnt_reg == 3'd3) begin
                    state_next = phl_pkg::ST_ROTW;
                end
            end
            phl_pkg::ST_ROTW: begin
                if (chain_out.valid && !chain_out.vec && chain_out.tag == phl_pkg::TAG_CLB) begin
                    state_next = phl_pkg::ST_MUL;
                end
            end
            phl_pkg::ST_MUL: begin
                if (cnt_reg == 3'd5) begin
                    state_next = phl_pkg::ST_SQS;
                end
            end
            phl_pkg::ST_SQS:   state_next = phl_pkg::ST_SQRT;
            phl_pkg::ST_SQRT: begin
                if (ys_done) begin
                    state_next = phl_pkg::ST_ATAN;
                end
            end
            phl_pkg::ST_ATAN:  state_next = phl_pkg::ST_ATANW;
            phl_pkg::ST_ATANW: begin
                if (chain_out.valid && chain_out.vec) begin
                    state_next = phl_pkg::ST_SCALE;
                end
            end
            phl_pkg::ST_SCALE: state_next = phl_pkg::ST_MM;
            phl_pkg::ST_MM:    state_next = phl_pkg::ST_OUT;
            phl_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = phl_pkg::ST_IDLE;
                end
            end
            default:           state_next = phl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        conv_issue = 1'b0;
        atan_issue = 1'b0;
        sqrt_start = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            phl_pkg::ST_IDLE: s_tready   = 1'b1;
            phl_pkg::ST_CONV: conv_issue = 1'b1;
            phl_pkg::ST_SQS:  sqrt_start = 1'b1;
            phl_pkg::ST_ATAN: atan_issue = 1'b1;
            phl_pkg::ST_OUT:  commit     = out_free;
            default:          s_tready   = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= phl_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            // step counter restarts on every state change
            cnt_reg   <= (state_next != state_reg) ? 3'd0 : cnt_reg + 3'd1;
        end
    end

    // ---------------- point capture and angle prep ----------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_lat_reg <= $signed(s_tdata[30:0]);
            cur_lon_reg <= $signed(s_tdata[62:31]);
        end
        if (state_reg == phl_pkg::ST_PREP) begin
            dlat_reg               <= wrap_deg(34'(cur_lat_reg) - 34'(prev_lat_reg));
            dlon_reg               <= wrap_deg(34'(cur_lon_reg) - 34'(prev_lon_reg));
            {neg_a_reg, la_reg}    <= fold_lat(prev_lat_reg);
            {neg_b_reg, lb_reg}    <= fold_lat(cur_lat_reg);
        end
    end

    // degrees to Q30 radians: multiply here, round and shift on the way into the row
    always_comb begin
        case (cnt_reg[1:0])
            phl_pkg::TAG_SLAT: conv_d = dlat_reg;
            phl_pkg::TAG_SLON: conv_d = dlon_reg;
            phl_pkg::TAG_CLA:  conv_d = la_reg;
            default:           conv_d = lb_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conv_v_reg <= 1'b0;
        end else begin
            conv_v_reg <= conv_issue;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= 64'(conv_d) * 64'(phl_pkg::DEG_TO_Q30);
        conv_tag_reg <= cnt_reg[1:0];
    end

    always_comb begin
        if (conv_tag_reg == phl_pkg::TAG_SLAT || conv_tag_reg == phl_pkg::TAG_SLON) begin
            // half angle: one more bit of shift
            zsum = prod_reg + (64'sd1 <<< 30);
            zq   = zsum >>> 31;
        end else begin
            zsum = prod_reg + (64'sd1 <<< 29);
            zq   = zsum >>> 30;
        end
    end

    // ---------------- CORDIC cell row ----------------
    always_comb begin
        feed = '0;
        if (conv_v_reg) begin
            feed.valid = 1'b1;
            feed.vec   = 1'b0;
            feed.tag   = conv_tag_reg;
            feed.x     = $signed(phl_pkg::XW'(phl_pkg::GAIN_Q30));
            feed.y     = '0;
            feed.z     = zq[phl_pkg::ZW-1:0];
        end else if (atan_issue) begin
            feed.valid = 1'b1;
            feed.vec   = 1'b1;
            feed.tag   = phl_pkg::TAG_SLAT;
            feed.x     = $signed(phl_pkg::XW'(xc_root));
            feed.y     = $signed(phl_pkg::XW'(ys_root));
            feed.z     = '0;
        end
    end

    assign chain_w[0] = feed;

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        phl_cordic_cell #(
            .STEP(i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_in  (chain_w[i]),
            .cell_out (chain_w[i+1])
        );
    end

    assign neg_x = -chain_out.x;

    // sort finished rotations by tag; vectoring result is the half central angle
    always_ff @(posedge aclk) begin
        if (chain_out.valid && !chain_out.vec) begin
            case (chain_out.tag)
                phl_pkg::TAG_SLAT: sl_reg <= chain_out.y[31:0];
                phl_pkg::TAG_SLON: sn_reg <= chain_out.y[31:0];
                phl_pkg::TAG_CLA:  ca_reg <= neg_a_reg ? neg_x[31:0] : chain_out.x[31:0];
                phl_pkg::TAG_CLB:  cb_reg <= neg_b_reg ? neg_x[31:0] : chain_out.x[31:0];
                default:           sl_reg <= sl_reg;
            endcase
        end
        if (chain_out.valid && chain_out.vec) begin
            ang_reg <= chain_out.z[phl_pkg::ZW-1] ? 32'd0 : {chain_out.z[30:0], 1'b0};
        end
    end

    // ---------------- haversine products on one shared multiplier ----------------
    always_comb begin
        case (cnt_reg)
            3'd0:    begin mul_a = ca_reg;  mul_b = cb_reg; end
            3'd1:    begin mul_a = sl_reg;  mul_b = sl_reg; end
            3'd2:    begin mul_a = cc_reg;  mul_b = sn_reg; end
            3'd4:    begin mul_a = t_reg;   mul_b = sn_reg; end
            default: begin mul_a = '0;      mul_b = '0;     end
        endcase
    end

    assign mul_sh  = mul_reg >>> 30;
    assign mul_q30 = mul_sh[31:0];
    assign hs      = 33'(hsl_reg) + 33'(mul_q30);

    always_comb begin
        if (hs[32]) begin
            h_clamp = '0;
        end else if (hs > (33'sd1 <<< 30)) begin
            h_clamp = 31'd1 << 30;
        end else begin
            h_clamp = hs[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        mul_reg <= 64'(mul_a) * 64'(mul_b);
        if (state_reg == phl_pkg::ST_MUL) begin
            case (cnt_reg)
                3'd1:    cc_reg  <= mul_q30;
                3'd2:    hsl_reg <= mul_q30;
                3'd3:    t_reg   <= mul_q30;
                3'd5:    h_reg   <= h_clamp;
                default: cc_reg  <= cc_reg;
            endcase
        end
    end

    // ---------------- square roots of h and 1 - h ----------------
    phl_isqrt u_sqrt_ys (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand ({h_reg, 30'd0}),
        .done     (ys_done),
        .root     (ys_root)
    );

    phl_isqrt u_sqrt_xc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand ({(31'd1 << 30) - h_reg, 30'd0}),
        .done     (xc_done),
        .root     (xc_root)
    );

    // ---------------- scale to millimetres ----------------
    assign mm = 36'(q_reg[54:30]) * 36'(phl_pkg::MM_PER_M)
              + 36'((41'(q_reg[29:0]) * 41'(phl_pkg::MM_PER_M) + (41'd1 << 29)) >> 30);

    always_ff @(posedge aclk) begin
        if (state_reg == phl_pkg::ST_SCALE) begin
            q_reg <= 55'(radius_reg) * 55'(ang_reg);
        end
        if (accept) begin
            seg_reg <= '0;
        end else if (state_reg == phl_pkg::ST_MM) begin
            seg_reg <= mm[34:0];
        end
    end

    // ---------------- running total and result register ----------------
    assign sum = {1'b0, total_reg} + 49'(seg_reg);

    always_comb begin
        total_new = total_reg;
        sat_new   = sat_reg;
        if (first_reg) begin
            total_new = '0;
            sat_new   = 1'b0;
        end else if (calc_reg) begin
            if (sum >= 49'(phl_pkg::TOTAL_MAX)) begin
                total_new = phl_pkg::TOTAL_MAX;
                sat_new   = 1'b1;
            end else begin
                total_new = sum[47:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg    <= phl_pkg::RADIUS_RST;
            prev_lat_reg  <= '0;
            prev_lon_reg  <= '0;
            have_prev_reg <= 1'b0;
            total_reg     <= '0;
            sat_reg       <= 1'b0;
            first_reg     <= 1'b0;
            calc_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                radius_reg <= cfg_data;
            end
            if (accept) begin
                first_reg <= s_tuser;
                calc_reg  <= !s_tuser && have_prev_reg;
            end
            if (commit) begin
                total_reg     <= total_new;
                sat_reg       <= sat_new;
                prev_lat_reg  <= cur_lat_reg;
                prev_lon_reg  <= cur_lon_reg;
                have_prev_reg <= 1'b1;
                m_tvalid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_seg_reg   <= seg_reg;
            m_total_reg <= total_new;
            m_sat_reg   <= sat_new;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_total_reg, m_seg_reg};
    assign m_tuser  = m_sat_reg;

`ifndef SYNTHESIS
    a_sat_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_sat_reg |-> m_total_reg == phl_pkg::TOTAL_MAX)
        else $error("saturated result without a full total");

    a_row_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_out.valid |-> state_reg == phl_pkg::ST_ROTW || state_reg == phl_pkg::ST_ATANW)
        else $error("CORDIC result arrived outside a wait state");

    a_sqrt_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        ys_done || xc_done |-> ys_done && xc_done && state_reg == phl_pkg::ST_SQRT)
        else $error("square root units out of step");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == phl_pkg::ST_OUT && !out_free |=> $stable(total_reg) && m_tvalid_reg)
        else $error("total moved while the result was stalled");

    a_one_point: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("second point taken while one is in flight");
`endif

endmodule

`default_nettype wire

@@ rtl/core/phl_cordic_cell.sv @@
`default_nettype none

module phl_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  phl_pkg::cord_t      cell_in,
    output phl_pkg::cord_t      cell_out
);

    phl_pkg::cord_t                cell_reg;
    phl_pkg::cord_t                cell_next;
    logic signed [phl_pkg::XW-1:0] xs;
    logic signed [phl_pkg::XW-1:0] ys;
    logic signed [phl_pkg::ZW-1:0] at;
    logic                          ccw;

    assign xs = cell_in.x >>> STEP;
    assign ys = cell_in.y >>> STEP;
    assign at = $signed(phl_pkg::ZW'(phl_pkg::ATAN_Q30[STEP]));
    // rotation steers on the residual angle, vectoring on the sign of y
    assign ccw = cell_in.vec ? cell_in.y[phl_pkg::XW-1] : !cell_in.z[phl_pkg::ZW-1];

    always_comb begin
        cell_next = cell_in;
        if (ccw) begin
            cell_next.x = cell_in.x - ys;
            cell_next.y = cell_in.y + xs;
            cell_next.z = cell_in.z - at;
        end else begin
            cell_next.x = cell_in.x + ys;
            cell_next.y = cell_in.y - xs;
            cell_next.z = cell_in.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

@@ rtl/core/phl_isqrt.sv @@
`default_nettype none

module phl_isqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [60:0] radicand,
    output logic             done,
    output logic [30:0]      root
);

    logic [60:0] rem_reg;
    logic [60:0] root_reg;
    logic [60:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [61:0] trial;
    logic        fits;

    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};
    assign fits  = {1'b0, rem_reg} >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // one result bit per cycle, trial bit walks down by two places
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= radicand;
            root_reg <= '0;
            bit_reg  <= 61'(1) << 60;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg  <= rem_reg - trial[60:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = root_reg[30:0];

endmodule

`default_nettype wire
